// ----- sv/sro_pkg.sv -----
`default_nettype none

package sro_pkg;

	localparam int DefWaitDepth = 32;
	localparam int IdxW = 32;
	localparam int HdlW = 16;
	localparam int LimW = 5;
	localparam logic [LimW-1:0] LimReset = 5'd31;
	localparam int TdataW = 48;

	localparam logic KindRelease = 1'b0;
	localparam logic KindError = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_PROBE_DUP,
		S_PARK,
		S_PROBE_NEXT,
		S_LOAD_NEXT,
		S_CHAIN,
		S_ERR
	} state_t;

	typedef enum logic {
		KEY_INPUT,
		KEY_EXPECTED
	} key_sel_t;

	typedef struct packed {
		logic load_in;
		logic direct;
		logic probe;
		key_sel_t key_sel;
		logic park;
		logic set_halt;
		logic release_slot;
		logic take_mem;
		logic emit_last;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic halted;
		logic idx_eq_exp;
		logic match_any;
		logic overflow;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- sv/sro_ctrl.sv -----
`default_nettype none

module sro_ctrl
	import sro_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.halted) state_nxt = S_ERR;
				else if (sts.idx_eq_exp) state_nxt = S_PROBE_NEXT;
				else state_nxt = S_PROBE_DUP;
			end
			S_PROBE_DUP: state_nxt = S_PARK;
			S_PARK: begin
				if (!sts.match_any && sts.overflow) state_nxt = S_ERR;
				else state_nxt = S_IDLE;
			end
			S_PROBE_NEXT: state_nxt = S_CHAIN;
			S_LOAD_NEXT: state_nxt = S_CHAIN;
			S_CHAIN: begin
				if (sts.out_free) state_nxt = sts.match_any ? S_LOAD_NEXT : S_IDLE;
			end
			S_ERR: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.key_sel = KEY_EXPECTED;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			S_DECIDE: cmd.direct = !sts.halted && sts.idx_eq_exp;
			S_PROBE_DUP: begin
				cmd.probe = 1'b1;
				cmd.key_sel = KEY_INPUT;
			end
			S_PARK: begin
				cmd.park = !sts.match_any && !sts.overflow;
				cmd.set_halt = !sts.match_any && sts.overflow;
			end
			S_PROBE_NEXT: cmd.probe = 1'b1;
			S_LOAD_NEXT: begin
				cmd.probe = 1'b1;
				cmd.take_mem = 1'b1;
			end
			S_CHAIN: begin
				cmd.release_slot = sts.out_free && sts.match_any;
				cmd.emit_last = sts.out_free && !sts.match_any;
			end
			S_ERR: cmd.emit_err = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/sro_dp.sv -----
`default_nettype none

module sro_dp
	import sro_pkg::*;
#(
	parameter int WAIT_DEPTH = DefWaitDepth
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire cmd_t         cmd,
	output sts_t              sts,
	input  wire  [IdxW-1:0]   in_index,
	input  wire  [HdlW-1:0]   in_handle,
	input  wire               cfg_we,
	input  wire  [LimW-1:0]   cfg_limit,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              out_kind,
	output logic [HdlW-1:0]   out_handle,
	output logic [IdxW-1:0]   out_index,
	output logic              out_last
);

	localparam int SlotW = $clog2(WAIT_DEPTH);
	localparam int CntW = $clog2(WAIT_DEPTH + 1);
	localparam int CmpW = (CntW > LimW) ? CntW : LimW;

	logic [IdxW-1:0]       idx_q;
	logic [HdlW-1:0]       hdl_q;
	logic [IdxW-1:0]       exp_q;
	logic [WAIT_DEPTH-1:0] valid_q;
	logic [IdxW-1:0]       eidx_q [WAIT_DEPTH];
	logic [HdlW-1:0]       hdl_mem [WAIT_DEPTH];
	logic [HdlW-1:0]       mem_rd_q;
	logic [WAIT_DEPTH-1:0] match_q;
	logic [SlotW-1:0]      free_idx_q;
	logic                  free_any_q;
	logic [CntW-1:0]       count_q;
	logic                  halt_q;
	logic [LimW-1:0]       limit_q;
	logic [HdlW-1:0]       cur_hdl_q;
	logic [IdxW-1:0]       cur_idx_q;
	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [HdlW-1:0]       out_hdl_q;
	logic [IdxW-1:0]       out_idx_q;
	logic                  out_last_q;

	logic [IdxW-1:0]       key;
	logic [WAIT_DEPTH-1:0] match_nxt;
	logic [SlotW-1:0]      free_nxt;
	logic [SlotW-1:0]      hit_slot;
	logic                  out_free;
	logic                  emit;

	assign key = (cmd.key_sel == KEY_INPUT) ? idx_q : exp_q;
	assign out_free = !out_valid_q || out_ready;
	assign emit = cmd.release_slot || cmd.emit_last || cmd.emit_err;

	// parallel tag compare, one comparator per entry
	always_comb begin
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			match_nxt[i] = valid_q[i] && (eidx_q[i] == key);
		end
	end

	// lowest free slot
	always_comb begin
		free_nxt = '0;
		for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_nxt = SlotW'(i);
		end
	end

	// match vector is one-hot: indices in the table are unique
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			if (match_q[i]) hit_slot = hit_slot | SlotW'(i);
		end
	end

	always_comb begin
		sts.halted = halt_q;
		sts.idx_eq_exp = (idx_q == exp_q);
		sts.match_any = |match_q;
		sts.overflow = (CmpW'(count_q) > CmpW'(limit_q)) || !free_any_q;
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			valid_q <= '0;
			count_q <= '0;
			halt_q <= 1'b0;
			limit_q <= LimReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_limit;
			if (cmd.direct || cmd.release_slot) exp_q <= exp_q + 1'b1;
			if (cmd.park) begin
				valid_q[free_idx_q] <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.release_slot) begin
				valid_q[hit_slot] <= 1'b0;
				count_q <= count_q - 1'b1;
			end
			if (cmd.set_halt) halt_q <= 1'b1;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			idx_q <= in_index;
			hdl_q <= in_handle;
		end
		if (cmd.probe) match_q <= match_nxt;
		free_idx_q <= free_nxt;
		free_any_q <= !(&valid_q);
		if (cmd.park) begin
			eidx_q[free_idx_q] <= idx_q;
			hdl_mem[free_idx_q] <= hdl_q;
		end
		mem_rd_q <= hdl_mem[hit_slot];
		if (cmd.direct) begin
			cur_hdl_q <= hdl_q;
			cur_idx_q <= idx_q;
		end
		if (cmd.release_slot) cur_idx_q <= exp_q;
		if (cmd.take_mem) cur_hdl_q <= mem_rd_q;
		if (cmd.release_slot || cmd.emit_last) begin
			out_kind_q <= KindRelease;
			out_hdl_q <= cur_hdl_q;
			out_idx_q <= cur_idx_q;
			out_last_q <= cmd.emit_last;
		end
		if (cmd.emit_err) begin
			out_kind_q <= KindError;
			out_hdl_q <= '0;
			out_idx_q <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_handle = out_hdl_q;
	assign out_index = out_idx_q;
	assign out_last = out_last_q;

endmodule

`default_nettype wire

// ----- sv/sequence_reorder_buffer_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: order_index, frame_handle
// m_axis    out  tvalid/tready          tdata: released_handle, released_index;
//                                       tuser: kind; tlast: last of a transaction's results
// cfg       in   cfg_valid/cfg_ready    cfg_data: wait_limit
//
// One input at a time, taken only in idle; the decision is made in the cycle after accept.
// States after accept: decide, probe, park for a parked or dropped frame, then error on an
// overflow; decide, probe, chain for a direct release, plus load and chain per frame
// drained (tag compare register, then handle memory read); decide, error while halted.
// An untaken result in the output register holds the chain or error state in place.
// Reset clears expected index, valid bits, count, halt flag, sets limit 31; no clearing pass.

module sequence_reorder_buffer_unit
	import sro_pkg::*;
#(
	parameter int WAIT_DEPTH = DefWaitDepth
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire  [TdataW-1:0]  s_axis_tdata,   // [31:0] order_index, [47:32] frame_handle
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [TdataW-1:0]  m_axis_tdata,   // [15:0] released_handle, [47:16] released_index
	output logic               m_axis_tuser,   // [0] kind
	output logic               m_axis_tlast,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [LimW-1:0]    cfg_data        // wait_limit
);

	cmd_t cmd;
	sts_t sts;
	logic [HdlW-1:0] out_handle;
	logic [IdxW-1:0] out_index;

	// limit register is always writable
	assign cfg_ready = 1'b1;

	sro_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sro_dp #(
		.WAIT_DEPTH(WAIT_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_index   (s_axis_tdata[IdxW-1:0]),
		.in_handle  (s_axis_tdata[IdxW+HdlW-1:IdxW]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_limit  (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (m_axis_tuser),
		.out_handle (out_handle),
		.out_index  (out_index),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {out_index, out_handle};

	// only one result may be pushed per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.release_slot, cmd.emit_last, cmd.emit_err}))
		else $error("more than one result pushed in a cycle");

	// a push never overwrites an untaken result
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.release_slot || cmd.emit_last || cmd.emit_err) |-> sts.out_free)
		else $error("result pushed into a full output register");

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.halted |=> sts.halted)
		else $error("halt flag dropped without reset");

	// nothing is parked or released once halted
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sts.halted |-> !(cmd.park || cmd.direct))
		else $error("table activity while halted");

endmodule

`default_nettype wire

// ----- sim/sequence_reorder_buffer_unit_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sequence reorder buffer.
// Frames go in on s_axis as {frame_handle, order_index}; the bench keeps its own
// picture of the waiting table and works out, for every accepted frame, the
// releases (or the error) the block must produce. Every m_axis transaction is
// matched against the oldest pending prediction.
module sequence_reorder_buffer_unit_tb;
	import sro_pkg::*;

	localparam int Depth    = DefWaitDepth;
	localparam int HoldOff  = 400;          // long receiver stall, in cycles
	localparam int TailWait = 20;           // cycles to watch after the last result

	// one predicted m_axis transaction
	typedef struct packed {
		logic            kind;
		logic [HdlW-1:0] hdl;
		logic [IdxW-1:0] idx;
		logic            last;
	} release_t;

	typedef enum logic {ROW_FRAME, ROW_LIMIT} row_op_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_RELEASE, CHK_ERROR} row_chk_t;

	// directed row: rel set means idx is an offset from the next wanted index;
	// a ROW_LIMIT row carries the new wait_limit in hdl
	typedef struct packed {
		row_op_t         op;
		logic            rel;
		logic [IdxW-1:0] idx;
		logic [HdlW-1:0] hdl;
		row_chk_t        chk;
	} row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [TdataW-1:0] s_axis_tdata = '0;   // [31:0] order_index, [47:32] frame_handle
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [TdataW-1:0] m_axis_tdata;        // [15:0] released_handle, [47:16] released_index
	logic              m_axis_tuser;        // [0] kind
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LimW-1:0]   cfg_data = '0;       // wait_limit

	sequence_reorder_buffer_unit #(
		.WAIT_DEPTH(Depth)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: the bench's own copy of the waiting table
	// ------------------------------------------------------------------
	logic [IdxW-1:0] ord_next;              // index the block wants next
	logic            slot_used [Depth];
	logic [IdxW-1:0] slot_idx  [Depth];
	logic [HdlW-1:0] slot_hdl  [Depth];
	int              parked_n;
	logic            stuck;                 // halted after an overflow
	logic [LimW-1:0] wait_lim;

	release_t due_releases [$];             // predictions not yet seen on m_axis

	int  fails;
	int  n_frames;
	int  n_results;
	int  n_writes;
	int  longest_chain;
	int  burst_left;
	bit  hold_req;                          // stimulus asks the receiver to hold off

	function automatic int find_slot(input logic [IdxW-1:0] key);
		for (int i = 0; i < Depth; i++)
			if (slot_used[i] && slot_idx[i] == key)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < Depth; i++)
			if (!slot_used[i])
				return i;
		return -1;
	endfunction

	// Works out what one accepted frame causes. With keep clear the state is
	// advanced but the results are dropped (the row supplies its own).
	task automatic predict_release(input logic [IdxW-1:0] idx, input logic [HdlW-1:0] hdl,
			input bit keep);
		release_t batch [$];
		release_t r;
		logic     overflow;
		int       s;
		overflow = 1'b0;
		if (stuck) begin
			overflow = 1'b1;
		end else if (idx == ord_next) begin
			r.kind = KindRelease; r.hdl = hdl; r.idx = idx; r.last = 1'b0;
			batch.push_back(r);
			ord_next = ord_next + 1'b1;
		end else if (find_slot(idx) < 0) begin
			// duplicates fall through untouched
			s = free_slot();
			if (parked_n > int'(wait_lim) || s < 0) begin
				overflow = 1'b1;
				stuck = 1'b1;
			end else begin
				slot_used[s] = 1'b1;
				slot_idx[s] = idx;
				slot_hdl[s] = hdl;
				parked_n++;
			end
		end
		if (overflow) begin
			r.kind = KindError; r.hdl = '0; r.idx = '0; r.last = 1'b1;
			batch.push_back(r);
		end else begin
			// drain whatever now lines up behind the wanted index
			s = find_slot(ord_next);
			while (s >= 0) begin
				r.kind = KindRelease; r.hdl = slot_hdl[s]; r.idx = slot_idx[s]; r.last = 1'b0;
				batch.push_back(r);
				slot_used[s] = 1'b0;
				if (parked_n > 0)
					parked_n--;
				ord_next = ord_next + 1'b1;
				s = find_slot(ord_next);
			end
			if (batch.size() > 0)
				batch[batch.size()-1].last = 1'b1;
		end
		if (batch.size() > longest_chain)
			longest_chain = batch.size();
		if (keep)
			foreach (batch[i])
				due_releases.push_back(batch[i]);
	endtask

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offers one frame and blocks until the transaction happens. tvalid is left
	// high inside a burst; at a burst end it drops for a random gap.
	task automatic send_frame(input logic [IdxW-1:0] idx, input logic [HdlW-1:0] hdl,
			input row_chk_t chk);
		release_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hdl, idx};
		do @(posedge clk); while (!s_axis_tready);
		n_frames++;
		predict_release(idx, hdl, chk == CHK_MODEL);
		if (chk == CHK_RELEASE) begin
			r.kind = KindRelease; r.hdl = hdl; r.idx = idx; r.last = 1'b1;
			due_releases.push_back(r);
		end else if (chk == CHK_ERROR) begin
			r.kind = KindError; r.hdl = '0; r.idx = '0; r.last = 1'b1;
			due_releases.push_back(r);
		end
		burst_left--;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
		end
	endtask

	// Waits until the block is idle: every prediction seen, then a few cycles
	// for a parked or dropped frame that produces nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (due_releases.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LimW-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		wait_lim = v;
		n_writes++;
	endtask

	row_t stim_rows [0:23];

	task automatic run_rows(input int lo, input int hi);
		logic [IdxW-1:0] idx;
		for (int i = lo; i <= hi; i++) begin
			if (stim_rows[i].op == ROW_LIMIT) begin
				write_limit(stim_rows[i].hdl[LimW-1:0]);
			end else begin
				idx = stim_rows[i].rel ? ord_next + stim_rows[i].idx : stim_rows[i].idx;
				send_frame(idx, stim_rows[i].hdl, stim_rows[i].chk);
			end
		end
	endtask

	// One random phase: a limit write, then shuffled windows of consecutive
	// indices sized so the table cannot overflow. big sends one full-depth
	// window in falling order (one frame then frees the longest chain);
	// wide sprinkles in a few far-off indices that stay parked for good.
	task automatic run_phase(input logic [LimW-1:0] lim, input int items, input bit big,
			input bit wide);
		logic [IdxW-1:0] w [0:Depth];
		logic [IdxW-1:0] t;
		logic [IdxW-1:0] base;
		int sent, k, kmax, j, stale;
		write_limit(lim);
		sent = 0;
		stale = 0;
		while (sent < items) begin
			if (wide && stale < 6 && $urandom_range(0, 5) == 0) begin
				send_frame($urandom | 32'h8000_0000, HdlW'($urandom_range(0, 16'hFFFF)),
					CHK_MODEL);
				stale++;
			end
			base = ord_next;
			kmax = int'(wait_lim) + 2 - parked_n;
			if (big) begin
				k = Depth + 1;
				for (int i = 0; i < k; i++)
					w[i] = base + (k - 1 - i);
				big = 1'b0;
			end else begin
				if (kmax > 8 && $urandom_range(0, 9) != 0)
					kmax = 8;
				k = $urandom_range(1, kmax);
				for (int i = 0; i < k; i++)
					w[i] = base + i;
				for (int i = k - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = w[i]; w[i] = w[j]; w[j] = t;
				end
			end
			for (int i = 0; i < k; i++) begin
				send_frame(w[i], HdlW'($urandom_range(0, 16'hFFFF)), CHK_MODEL);
				sent++;
				// now and then resend a parked index: must be dropped
				if (find_slot(w[i]) >= 0 && $urandom_range(0, 7) == 0)
					send_frame(w[i], HdlW'($urandom_range(0, 16'hFFFF)), CHK_MODEL);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		ord_next = '0;
		parked_n = 0;
		stuck = 1'b0;
		wait_lim = LimReset;
		for (int i = 0; i < Depth; i++) begin
			slot_used[i] = 1'b0;
			slot_idx[i] = '0;
			slot_hdl[i] = '0;
		end
		fails = 0;
		n_frames = 0;
		n_results = 0;
		n_writes = 0;
		longest_chain = 0;
		burst_left = 4;
		hold_req = 1'b0;

		stim_rows = '{
			// opening: release after reset, park, duplicate, chain of two
			'{ROW_FRAME, 1'b0, 32'd0, 16'hFFFF, CHK_RELEASE},
			'{ROW_FRAME, 1'b1, 32'd1, 16'h0000, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd1, 16'h1234, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd0, 16'h0001, CHK_MODEL},
			// limit 0: a single frame may still park
			'{ROW_LIMIT, 1'b0, 32'd0, 16'd0,    CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd1, 16'h8000, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd0, 16'h7FFF, CHK_MODEL},
			// limit 1: two parked, then a chain of three
			'{ROW_LIMIT, 1'b0, 32'd0, 16'd1,    CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd2, 16'hAAAA, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd1, 16'h5555, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd0, 16'hFFFF, CHK_MODEL},
			'{ROW_LIMIT, 1'b0, 32'd0, 16'd31,   CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd3, 16'h0F0F, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd1, 16'hF0F0, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd2, 16'h00FF, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd0, 16'hFF00, CHK_MODEL},
			// closing: top index parked, limit dropped under the count,
			// parked frames still drain, then overflow and the halted state
			'{ROW_FRAME, 1'b0, 32'hFFFF_FFFF, 16'hA5A5, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd1, 16'h3C3C, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd2, 16'hC3C3, CHK_MODEL},
			'{ROW_LIMIT, 1'b0, 32'd0, 16'd0,    CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd0, 16'h0000, CHK_MODEL},
			'{ROW_FRAME, 1'b1, 32'd7, 16'hFFFF, CHK_ERROR},
			'{ROW_FRAME, 1'b1, 32'd0, 16'h1111, CHK_ERROR},
			'{ROW_FRAME, 1'b0, 32'd0, 16'hFFFF, CHK_ERROR}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_rows(0, 15);

		// first random phase starts under a long receiver stall
		hold_req = 1'b1;
		run_phase(5'd31, 60, 1'b0, 1'b0);
		run_phase(5'd0, 50, 1'b0, 1'b0);
		run_phase(5'd1, 50, 1'b0, 1'b0);
		run_phase(5'd31, 40, 1'b1, 1'b0);
		run_phase(LimW'($urandom_range(2, 30)), 50, 1'b0, 1'b0);
		run_phase(5'd15, 50, 1'b0, 1'b0);
		run_phase(5'd31, 60, 1'b0, 1'b1);
		settle();

		run_rows(16, 23);

		s_axis_tvalid <= 1'b0;
		while (due_releases.size() != 0) @(posedge clk);
		repeat (TailWait) @(posedge clk);

		$display("Covered %0d frames, %0d results checked, %0d wait_limit writes",
			n_frames, n_results, n_writes);
		$display("Longest release chain %0d, ended in the halted state, %0d mismatches",
			longest_chain, fails);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random ready patterns, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int mode, len;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				for (int c = 0; c < HoldOff; c++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(8, 64);
				for (int c = 0; c < len; c++) begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= 1'($urandom_range(0, 1));
						2: m_axis_tready <= ($urandom_range(0, 3) == 0);
						default: m_axis_tready <= (c % 3 != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		release_t got;
		release_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.hdl = m_axis_tdata[15:0];
			got.idx = m_axis_tdata[47:16];
			got.last = m_axis_tlast;
			n_results++;
			if (due_releases.size() == 0) begin
				if (fails < 10)
					$display("%t unexpected result kind %0d hdl %h idx %h last %0d",
						$realtime, got.kind, got.hdl, got.idx, got.last);
				fails++;
			end else begin
				want = due_releases.pop_front();
				if (got.kind != want.kind || got.hdl != want.hdl || got.idx != want.idx ||
						got.last != want.last) begin
					if (fails < 10)
						$display("%t mismatch: kind %0d/%0d hdl %h/%h idx %h/%h last %0d/%0d",
							$realtime, want.kind, got.kind, want.hdl, got.hdl,
							want.idx, got.idx, want.last, got.last);
					fails++;
				end
			end
		end
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Timeout with %0d results still pending", due_releases.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
